/* src/lpc_pkg.sv */
// Shared types and constants of the lane profile checker.
// No dependencies; compiled first.
package lpc_pkg;

    localparam int PIXEL_W    = 8;
    localparam int TENTHS_W   = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int WIN_LEN    = 5;

    // Colour code of one pixel / one run.
    typedef enum logic [1:0] {
        CODE_UNKNOWN = 2'd0,
        CODE_BLACK   = 2'd1,
        CODE_WHITE   = 2'd2,
        CODE_RED     = 2'd3
    } t_code;

    // Lane shape, oldest entry first. White marks the don't-care entry.
    localparam t_code LANE_SHAPE [WIN_LEN] = '{
        CODE_BLACK, CODE_RED, CODE_WHITE, CODE_RED, CODE_BLACK
    };
    localparam t_code SHAPE_ANY = CODE_WHITE;

    typedef logic [2:0] t_run_cnt;
    localparam t_run_cnt RUN_FULL = 3'(WIN_LEN);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLACK_LEVEL  = 3'd0,
        CFG_WHITE_LEVEL  = 3'd1,
        CFG_RED_LEVEL    = 3'd2,
        CFG_MAX_MAL_TEN  = 3'd3,
        CFG_MIN_CLR_TEN  = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        LV_CLEAR      = 2'd0,
        LV_OBSTRUCTED = 2'd1,
        LV_MALFORMED  = 2'd2
    } t_line_verdict;

    typedef enum logic [1:0] {
        FV_CLEAR      = 2'd0,
        FV_OBSTRUCTED = 2'd1,
        FV_NOT_EST    = 2'd2
    } t_frame_verdict;

    // Line event handed from the window stage to the tally stage.
    typedef struct packed {
        t_line_verdict lv;
        logic          fend;
    } t_line_ev;

endpackage

/* src/lpc_in_if.sv */
// Pixel request channel of the lane profile checker.
// Depends on lpc_pkg.
interface lpc_in_if import lpc_pkg::*; ;
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel;
    logic               line_end;
    logic               frame_end;

    modport source (output valid, pixel, line_end, frame_end, input ready);
    modport sink   (input valid, pixel, line_end, frame_end, output ready);
endinterface

/* src/lpc_out_if.sv */
// Line result channel of the lane profile checker.
// Depends on lpc_pkg.
interface lpc_out_if import lpc_pkg::*; ;
    logic           valid;
    logic           ready;
    t_line_verdict  line_verdict;
    logic           frame_valid;
    t_frame_verdict frame_verdict;

    modport source (output valid, line_verdict, frame_valid, frame_verdict, input ready);
    modport sink   (input valid, line_verdict, frame_valid, frame_verdict, output ready);
endinterface

/* src/lpc_win_cell.sv */
// One cell of the run window: holds one colour code, loads from its neighbor.
// Depends on lpc_pkg.
module lpc_win_cell import lpc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_shift,
    input  logic  i_clear,
    input  t_code i_code,
    output t_code o_code
);
    t_code r_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code <= CODE_UNKNOWN;
        end else if (i_clear) begin
            r_code <= CODE_UNKNOWN;
        end else if (i_shift) begin
            r_code <= i_code;
        end
    end

    assign o_code = r_code;
endmodule

/* src/lpc_tally.sv */
// Saturating line tally with frame clear.
// Depends on lpc_pkg (header import only).
module lpc_tally import lpc_pkg::*; #(
    parameter  int MAX_COUNT = 1023,
    localparam int W         = $clog2(MAX_COUNT + 1)
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_bump,
    input  logic         i_clear,
    output logic [W-1:0] o_next
);
    logic [W-1:0] r_count;

    // value after this cycle's bump, before any clear
    assign o_next = (i_bump && (r_count < W'(MAX_COUNT))) ? r_count + 1'b1 : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_clear) begin
            r_count <= '0;
        end else begin
            r_count <= o_next;
        end
    end
endmodule

/* src/lane_profile_checker_core.sv */
// Lane profile checker top level: run window, line tallies, frame verdict.
// Depends on lpc_pkg, lpc_in_if, lpc_out_if, lpc_win_cell, lpc_tally.
//
// Usage:
//  - i_in carries one pixel per request (pixel, line_end, frame_end).
//    A request moves when valid and ready are both high.
//  - o_out carries one result per line end or frame end: line verdict, and on a
//    frame end the frame verdict with frame_valid set. Other pixels give nothing.
//  - Config port: i_cfg_we/i_cfg_idx/i_cfg_data, write-only, one register
//    per cycle, to be written only while the block is idle.
// Throughput: one pixel per cycle, sustained, while o_out is taken.
// Path: a line-end pixel's result passes the line event reg, the tally
//  snapshot and the output reg, in that order, before it shows on o_out.
// Stalls: each of the three stages has its own valid bit; ready ripples
//  back per stage, so bubbles collapse and i_in stays ready as long as any
//  stage can still take a line event. A held-off o_out keeps its result.
// Reset (i_rst_n low, sync): levels back to 0/128/255, tenths to 3/7,
//  window, run count, match flag and all tallies cleared, pipeline empty.
module lane_profile_checker_core import lpc_pkg::*; #(
    parameter int MAX_LINES = 1023
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    lpc_in_if.sink                i_in,
    lpc_out_if.source             o_out
);
    localparam int TALLY_W = $clog2(MAX_LINES + 1);
    localparam int PROD_W  = TALLY_W + TENTHS_W;
    localparam logic [PROD_W-1:0] TEN = PROD_W'(10);

    // ---------------- configuration registers ----------------
    logic [PIXEL_W-1:0]  r_black_lvl, r_white_lvl, r_red_lvl;
    logic [TENTHS_W-1:0] r_max_mal_ten, r_min_clr_ten;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_black_lvl   <= PIXEL_W'(0);
            r_white_lvl   <= PIXEL_W'(128);
            r_red_lvl     <= PIXEL_W'(255);
            r_max_mal_ten <= TENTHS_W'(3);
            r_min_clr_ten <= TENTHS_W'(7);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BLACK_LEVEL: r_black_lvl   <= i_cfg_data[PIXEL_W-1:0];
                CFG_WHITE_LEVEL: r_white_lvl   <= i_cfg_data[PIXEL_W-1:0];
                CFG_RED_LEVEL:   r_red_lvl     <= i_cfg_data[PIXEL_W-1:0];
                CFG_MAX_MAL_TEN: r_max_mal_ten <= i_cfg_data[TENTHS_W-1:0];
                CFG_MIN_CLR_TEN: r_min_clr_ten <= i_cfg_data[TENTHS_W-1:0];
                default: ;  // unused indexes are ignored
            endcase
        end
    end

    // ---------------- handshake chain ----------------
    logic r_ev_vld, r_c_vld, r_o_vld;
    logic w_o_ready, w_c_ready, w_ev_ready, w_in_acc, w_ev_move;

    assign w_o_ready  = !r_o_vld || o_out.ready;
    assign w_c_ready  = !r_c_vld || w_o_ready;
    assign w_ev_ready = !r_ev_vld || w_c_ready;
    assign i_in.ready = w_ev_ready;
    assign w_in_acc   = i_in.valid && w_ev_ready;
    assign w_ev_move  = r_ev_vld && w_c_ready;

    // ---------------- colour mapping (black beats white beats red) ----------------
    t_code w_code;

    always_comb begin
        if (i_in.pixel == r_black_lvl) begin
            w_code = CODE_BLACK;
        end else if (i_in.pixel == r_white_lvl) begin
            w_code = CODE_WHITE;
        end else if (i_in.pixel == r_red_lvl) begin
            w_code = CODE_RED;
        end else begin
            w_code = CODE_UNKNOWN;
        end
    end

    // ---------------- run window: chain of cells, newest at the top ----------------
    t_code    w_win [WIN_LEN];
    t_code    w_next_win [WIN_LEN];
    logic     [WIN_LEN-1:0] w_hit;
    t_run_cnt r_run_cnt, n_run_cnt;
    logic     r_match, n_match;
    logic     w_shift, w_line_done;

    assign w_shift     = w_in_acc && ((r_run_cnt == '0) || (w_win[WIN_LEN-1] != w_code));
    assign w_line_done = w_in_acc && (i_in.line_end || i_in.frame_end);

    genvar gi;
    generate
        for (gi = 0; gi < WIN_LEN; gi++) begin : g_cell
            if (gi == WIN_LEN - 1) begin : g_top
                assign w_next_win[gi] = w_code;
            end else begin : g_mid
                assign w_next_win[gi] = w_win[gi+1];
            end

            lpc_win_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_clear (w_line_done),
                .i_code  (w_next_win[gi]),
                .o_code  (w_win[gi])
            );

            // don't-care entry always hits
            assign w_hit[gi] = (LANE_SHAPE[gi] == SHAPE_ANY) ||
                               (w_next_win[gi] == LANE_SHAPE[gi]);
        end
    endgenerate

    always_comb begin
        n_run_cnt = r_run_cnt;
        if (w_shift && (r_run_cnt < RUN_FULL)) begin
            n_run_cnt = r_run_cnt + 3'd1;
        end
        n_match = r_match || (w_shift && (n_run_cnt == RUN_FULL) && (&w_hit));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_cnt <= '0;
            r_match   <= 1'b0;
        end else if (w_line_done) begin
            r_run_cnt <= '0;
            r_match   <= 1'b0;
        end else if (w_in_acc) begin
            r_run_cnt <= n_run_cnt;
            r_match   <= n_match;
        end
    end

    // line verdict of the pixel just taken
    t_line_ev w_ev;

    always_comb begin
        w_ev.fend = i_in.frame_end;
        if (n_match) begin
            w_ev.lv = LV_CLEAR;
        end else if (n_run_cnt < RUN_FULL) begin
            w_ev.lv = LV_MALFORMED;
        end else begin
            w_ev.lv = LV_OBSTRUCTED;
        end
    end

    // ---------------- stage 1: line event register ----------------
    t_line_ev r_ev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev_vld <= 1'b0;
        end else if (w_ev_ready) begin
            r_ev_vld <= w_line_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ev_ready) begin
            r_ev <= w_ev;
        end
    end

    // ---------------- stage 2: tallies and frame snapshot ----------------
    logic [TALLY_W-1:0] w_clr_nx, w_obs_nx, w_mal_nx, w_tot_nx;
    logic               w_frame_clr;

    assign w_frame_clr = w_ev_move && r_ev.fend;

    lpc_tally #(.MAX_COUNT(MAX_LINES)) u_clr_tally (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_bump (w_ev_move && (r_ev.lv == LV_CLEAR)),
        .i_clear (w_frame_clr), .o_next (w_clr_nx)
    );
    lpc_tally #(.MAX_COUNT(MAX_LINES)) u_obs_tally (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_bump (w_ev_move && (r_ev.lv == LV_OBSTRUCTED)),
        .i_clear (w_frame_clr), .o_next (w_obs_nx)
    );
    lpc_tally #(.MAX_COUNT(MAX_LINES)) u_mal_tally (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_bump (w_ev_move && (r_ev.lv == LV_MALFORMED)),
        .i_clear (w_frame_clr), .o_next (w_mal_nx)
    );
    lpc_tally #(.MAX_COUNT(MAX_LINES)) u_tot_tally (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_bump (w_ev_move),
        .i_clear (w_frame_clr), .o_next (w_tot_nx)
    );

    t_line_ev           r_c_ev;
    logic [TALLY_W-1:0] r_c_clr, r_c_obs, r_c_mal, r_c_tot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (w_c_ready) begin
            r_c_vld <= r_ev_vld;
        end
    end

    // snapshot includes the line that just ended
    always_ff @(posedge i_clk) begin
        if (w_c_ready) begin
            r_c_ev  <= r_ev;
            r_c_clr <= w_clr_nx;
            r_c_obs <= w_obs_nx;
            r_c_mal <= w_mal_nx;
            r_c_tot <= w_tot_nx;
        end
    end

    // ---------------- stage 3: frame verdict and output register ----------------
    logic [PROD_W-1:0] w_mal10, w_clr10, w_mal_lim, w_clr_lim;
    t_frame_verdict    w_fv;

    assign w_mal10   = PROD_W'(r_c_mal) * TEN;
    assign w_clr10   = PROD_W'(r_c_clr) * TEN;
    assign w_mal_lim = PROD_W'(r_max_mal_ten) * PROD_W'(r_c_tot);
    assign w_clr_lim = PROD_W'(r_min_clr_ten) * PROD_W'(r_c_tot);

    always_comb begin
        if (!r_c_ev.fend) begin
            w_fv = FV_CLEAR;
        end else if (w_mal10 > w_mal_lim) begin
            w_fv = FV_NOT_EST;
        end else if (r_c_obs != '0) begin
            w_fv = FV_OBSTRUCTED;
        end else if (w_clr10 >= w_clr_lim) begin
            w_fv = FV_CLEAR;
        end else begin
            w_fv = FV_NOT_EST;
        end
    end

    t_line_verdict  r_o_lv;
    logic           r_o_fvld;
    t_frame_verdict r_o_fv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_o_ready) begin
            r_o_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_o_ready) begin
            r_o_lv   <= r_c_ev.lv;
            r_o_fvld <= r_c_ev.fend;
            r_o_fv   <= w_fv;
        end
    end

    assign o_out.valid         = r_o_vld;
    assign o_out.line_verdict  = r_o_lv;
    assign o_out.frame_valid   = r_o_fvld;
    assign o_out.frame_verdict = r_o_fv;

endmodule

/* verif/lane_profile_checker_core_test.sv */
// Self-checking testbench of lane_profile_checker_core: directed lines, then random
// frames under random stalls, checked against an in-bench line/frame verdict predictor.
// Depends on lpc_pkg, lpc_in_if, lpc_out_if and the core itself.
`timescale 1ns / 100ps

module lane_profile_checker_core_test;
    import lpc_pkg::*;

    localparam int LINE_CAP      = 63;      // tally saturation, small so one long frame hits it
    localparam int SETTLE_CYCLES = 8;       // three pipe stages plus margin
    localparam int CYCLE_CAP     = 500000;
    localparam int RANDOM_PIXELS = 450;
    localparam int LONG_HOLD     = 300;
    localparam int LONG_FRAME    = 70;      // lines; enough to saturate total and malformed

    typedef struct packed {
        logic [PIXEL_W-1:0] px;
        logic               lend;
        logic               fend;
    } t_pix_req;

    typedef struct packed {
        t_line_verdict  lv;
        logic           fvalid;
        t_frame_verdict fv;
    } t_verdict;

    typedef enum {LINE_LANE, LINE_SHORT, LINE_NOISE} t_line_kind;

    // Verdict predictor plus the queue of verdicts still owed by the core.
    class line_verdict_board;
        logic [PIXEL_W-1:0]  lvl_black, lvl_white, lvl_red;
        logic [TENTHS_W-1:0] mal_tenths, clr_tenths;
        t_code               run_win [WIN_LEN];
        int                  run_cnt;
        bit                  lane_hit;
        int                  n_clear, n_obst, n_mal, n_total;
        t_verdict            due_verdicts [$];
        int                  errors;

        function new();
            lvl_black  = 8'd0;
            lvl_white  = 8'd128;
            lvl_red    = 8'd255;
            mal_tenths = 4'd3;
            clr_tenths = 4'd7;
            clear_line();
            n_clear = 0;
            n_obst  = 0;
            n_mal   = 0;
            n_total = 0;
            errors  = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_BLACK_LEVEL: lvl_black  = val;
                CFG_WHITE_LEVEL: lvl_white  = val;
                CFG_RED_LEVEL:   lvl_red    = val;
                CFG_MAX_MAL_TEN: mal_tenths = val[TENTHS_W-1:0];
                CFG_MIN_CLR_TEN: clr_tenths = val[TENTHS_W-1:0];
                default: ;
            endcase
        endfunction

        // Black beats white beats red on level collisions.
        function t_code code_of(logic [PIXEL_W-1:0] px);
            if (px == lvl_black) return CODE_BLACK;
            if (px == lvl_white) return CODE_WHITE;
            if (px == lvl_red) return CODE_RED;
            return CODE_UNKNOWN;
        endfunction

        function bit lane_shape_hit();
            int i;
            for (i = 0; i < WIN_LEN; i++)
                if (LANE_SHAPE[i] != SHAPE_ANY && run_win[i] != LANE_SHAPE[i]) return 1'b0;
            return 1'b1;
        endfunction

        function void clear_line();
            int i;
            for (i = 0; i < WIN_LEN; i++) run_win[i] = CODE_UNKNOWN;
            run_cnt  = 0;
            lane_hit = 1'b0;
        endfunction

        function void bump(inout int tally);
            if (tally < LINE_CAP) tally++;
        endfunction

        function void note_pixel(t_pix_req req);
            t_code    c;
            t_verdict v;
            int       i;
            c = code_of(req.px);
            if (run_cnt == 0 || run_win[WIN_LEN-1] != c) begin
                for (i = 0; i < WIN_LEN - 1; i++) run_win[i] = run_win[i+1];
                run_win[WIN_LEN-1] = c;
                if (run_cnt < WIN_LEN) run_cnt++;
                if (run_cnt >= WIN_LEN && lane_shape_hit()) lane_hit = 1'b1;
            end
            if (!req.lend && !req.fend) return;

            v.fvalid = req.fend;
            v.fv     = FV_CLEAR;
            if (lane_hit) begin
                v.lv = LV_CLEAR;
                bump(n_clear);
            end else if (run_cnt < WIN_LEN) begin
                v.lv = LV_MALFORMED;
                bump(n_mal);
            end else begin
                v.lv = LV_OBSTRUCTED;
                bump(n_obst);
            end
            bump(n_total);
            clear_line();

            if (req.fend) begin
                if (n_mal * 10 > int'(mal_tenths) * n_total) v.fv = FV_NOT_EST;
                else if (n_obst > 0) v.fv = FV_OBSTRUCTED;
                else if (n_clear * 10 >= int'(clr_tenths) * n_total) v.fv = FV_CLEAR;
                else v.fv = FV_NOT_EST;
                n_clear = 0;
                n_obst  = 0;
                n_mal   = 0;
                n_total = 0;
            end
            due_verdicts.push_back(v);
        endfunction

        function void check_verdict(t_verdict got);
            t_verdict want;
            if (due_verdicts.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, got lv=%0d fvalid=%0d fv=%0d",
                         $time, got.lv, got.fvalid, got.fv);
                return;
            end
            want = due_verdicts.pop_front();
            if (got.lv !== want.lv) begin
                errors++;
                $display("%0t: line_verdict expected %0d got %0d", $time, want.lv, got.lv);
            end
            if (got.fvalid !== want.fvalid) begin
                errors++;
                $display("%0t: frame_valid expected %0d got %0d",
                         $time, want.fvalid, got.fvalid);
            end
            if (got.fv !== want.fv) begin
                errors++;
                $display("%0t: frame_verdict expected %0d got %0d", $time, want.fv, got.fv);
            end
        endfunction

        function int pending();
            return due_verdicts.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    lpc_in_if  pix_ch ();
    lpc_out_if verdict_ch ();

    lane_profile_checker_core #(
        .MAX_LINES (LINE_CAP)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (pix_ch),
        .o_out      (verdict_ch)
    );

    line_verdict_board board = new();

    t_pix_req pix_q [$];         // pixels queued for the sender
    int       n_pushed    = 0;   // pixels queued so far
    int       n_taken     = 0;   // pixels accepted by the core
    bit       rst_done    = 1'b0;
    bit       send_busy   = 1'b1; // sender inserts random gaps
    bit       recv_busy   = 1'b1; // receiver inserts random stalls
    int       hold_cycles = 0;   // one-shot long receiver hold-off
    int       cycle_cnt   = 0;

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) cycle_cnt <= cycle_cnt + 1;

    // Watchdog
    initial begin
        wait (cycle_cnt >= CYCLE_CAP);
        $display("== FAIL ==");
        $finish;
    end

    // Sender: pops queued pixels, gap before each request when busy.
    // valid gets exactly one NBA per time step.
    initial begin
        t_pix_req req;
        int       gap;
        pix_ch.valid     <= 1'b0;
        pix_ch.pixel     <= '0;
        pix_ch.line_end  <= 1'b0;
        pix_ch.frame_end <= 1'b0;
        wait (rst_done);
        forever begin
            if (pix_q.size() == 0) begin
                pix_ch.valid <= 1'b0;
                @(posedge i_clk);
            end else begin
                req = pix_q.pop_front();
                gap = send_busy ? $urandom_range(0, 9) : 0;
                if (gap > 0) begin
                    pix_ch.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                pix_ch.valid     <= 1'b1;
                pix_ch.pixel     <= req.px;
                pix_ch.line_end  <= req.lend;
                pix_ch.frame_end <= req.fend;
                @(posedge i_clk);
                while (!pix_ch.ready) @(posedge i_clk);
                board.note_pixel(req);
                n_taken++;
            end
        end
    end

    // Receiver: random stalls, long hold-off on request, checks every result taken.
    initial begin
        t_verdict got;
        int       stall;
        verdict_ch.ready <= 1'b0;
        wait (rst_done);
        forever begin
            if (hold_cycles > 0) begin
                stall       = hold_cycles;
                hold_cycles = 0;
            end else begin
                stall = recv_busy ? $urandom_range(0, 9) : 0;
            end
            if (stall > 0) begin
                verdict_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            verdict_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!verdict_ch.valid) @(posedge i_clk);
            got.lv     = verdict_ch.line_verdict;
            got.fvalid = verdict_ch.frame_valid;
            got.fv     = verdict_ch.frame_verdict;
            board.check_verdict(got);
            // flip between stalling and streaming now and then
            if ($urandom_range(0, 39) == 0) recv_busy = ~recv_busy;
        end
    end

    task automatic push_pix(logic [PIXEL_W-1:0] px, bit lend, bit fend);
        t_pix_req r;
        r.px   = px;
        r.lend = lend;
        r.fend = fend;
        pix_q.push_back(r);
        n_pushed++;
    endtask

    // Pixel value for a wanted code under the current levels; collisions
    // may remap it, which the predictor follows.
    function automatic logic [PIXEL_W-1:0] pixel_for(t_code c);
        logic [PIXEL_W-1:0] px;
        case (c)
            CODE_BLACK: px = board.lvl_black;
            CODE_WHITE: px = board.lvl_white;
            CODE_RED:   px = board.lvl_red;
            default: begin
                do px = 8'($urandom_range(0, 255));
                while (px == board.lvl_black || px == board.lvl_white || px == board.lvl_red);
            end
        endcase
        return px;
    endfunction

    function automatic t_code any_code();
        return t_code'($urandom_range(0, 3));
    endfunction

    // One scan line as a list of runs, each 1..3 pixels long.
    // A frame's last line sometimes ends on frame_end alone.
    task automatic push_line(t_line_kind kind, bit last_in_frame);
        t_code codes [$];
        int    n, i, r, reps;
        bit    drop_lend, last;
        case (kind)
            LINE_LANE: begin
                n = $urandom_range(0, 2);
                repeat (n) codes.push_back(any_code());
                codes.push_back(CODE_BLACK);
                codes.push_back(CODE_RED);
                case ($urandom_range(0, 2))
                    0:       codes.push_back(CODE_BLACK);
                    1:       codes.push_back(CODE_WHITE);
                    default: codes.push_back(CODE_UNKNOWN);
                endcase
                codes.push_back(CODE_RED);
                codes.push_back(CODE_BLACK);
                n = $urandom_range(0, 2);
                repeat (n) codes.push_back(any_code());
            end
            LINE_SHORT: begin
                n = $urandom_range(1, 4);
                repeat (n) codes.push_back(any_code());
            end
            default: begin
                n = $urandom_range(5, 12);
                repeat (n) codes.push_back(any_code());
            end
        endcase
        drop_lend = last_in_frame && ($urandom_range(0, 5) == 0);
        for (i = 0; i < codes.size(); i++) begin
            reps = $urandom_range(1, 3);
            for (r = 0; r < reps; r++) begin
                last = (i == codes.size() - 1) && (r == reps - 1);
                push_pix(pixel_for(codes[i]), last && !drop_lend, last && last_in_frame);
            end
        end
    endtask

    // Waits until the core has taken everything and owes nothing, then
    // lets the pipeline run dry (pixels without a result may still be inside).
    task automatic wait_idle();
        while (n_taken != n_pushed || board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        board.set_reg(idx, val);
    endtask

    task automatic apply_setting(logic [7:0] b, logic [7:0] w, logic [7:0] r,
                                 logic [7:0] mal, logic [7:0] clr);
        wait_idle();
        write_reg(CFG_BLACK_LEVEL, b);
        write_reg(CFG_WHITE_LEVEL, w);
        write_reg(CFG_RED_LEVEL, r);
        write_reg(CFG_MAX_MAL_TEN, mal);
        write_reg(CFG_MIN_CLR_TEN, clr);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] rand_level();
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'd255 : 8'd0;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] rand_tenths();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd10;
            2:       return 8'd15;
            default: return 8'($urandom_range(0, 15));
        endcase
    endfunction

    task automatic push_frame(int n_lines, bit busy);
        int         l, pick;
        t_line_kind kind;
        send_busy = busy;
        for (l = 0; l < n_lines; l++) begin
            pick = $urandom_range(0, 19);
            kind = (pick < 11) ? LINE_LANE : (pick < 15) ? LINE_SHORT : LINE_NOISE;
            push_line(kind, l == n_lines - 1);
            // occasional sender pause in mid-frame until the core owes nothing
            if ($urandom_range(0, 29) == 0) wait_idle();
        end
    endtask

    initial begin
        int         phase, frames, f, base, i;
        logic [7:0] b, w, r;

        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_BLACK_LEVEL;
        i_cfg_data <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n  <= 1'b1;
        rst_done = 1'b1;

        // Directed lines at reset levels (black 0, white 128, red 255).
        send_busy = 1'b0;
        // plain lane, white in the don't-care slot
        push_pix(8'd0, 1'b0, 1'b0); push_pix(8'd255, 1'b0, 1'b0);
        push_pix(8'd128, 1'b0, 1'b0); push_pix(8'd255, 1'b0, 1'b0);
        push_pix(8'd0, 1'b1, 1'b0);
        // sender pause inside the frame
        wait_idle();
        // lane with an unknown pixel in the middle, repeats dropped, frame end
        push_pix(8'd0, 1'b0, 1'b0); push_pix(8'd0, 1'b0, 1'b0);
        push_pix(8'd255, 1'b0, 1'b0); push_pix(8'd42, 1'b0, 1'b0);
        push_pix(8'd255, 1'b0, 1'b0); push_pix(8'd0, 1'b1, 1'b1);
        // one-run line: malformed
        push_pix(8'd0, 1'b0, 1'b0); push_pix(8'd0, 1'b1, 1'b0);
        // five runs, no lane, frame end without line end
        push_pix(8'd255, 1'b0, 1'b0); push_pix(8'd0, 1'b0, 1'b0);
        push_pix(8'd128, 1'b0, 1'b0); push_pix(8'd0, 1'b0, 1'b0);
        push_pix(8'd255, 1'b0, 1'b1);
        // unknown pixels form runs of their own
        send_busy = 1'b1;
        push_pix(8'd7, 1'b0, 1'b0); push_pix(8'd9, 1'b0, 1'b0);
        push_pix(8'd0, 1'b0, 1'b0); push_pix(8'd11, 1'b0, 1'b0);
        push_pix(8'd0, 1'b0, 1'b0); push_pix(8'd3, 1'b1, 1'b0);
        // all-red line, malformed, frame end with line end
        push_pix(8'd255, 1'b0, 1'b0); push_pix(8'd255, 1'b0, 1'b0);
        push_pix(8'd255, 1'b1, 1'b1);

        // Level collisions: all equal, then white and red equal.
        apply_setting(8'd100, 8'd100, 8'd100, 8'd3, 8'd7);
        push_pix(8'd100, 1'b0, 1'b0); push_pix(8'd5, 1'b0, 1'b0);
        push_pix(8'd100, 1'b0, 1'b0); push_pix(8'd5, 1'b0, 1'b0);
        push_pix(8'd100, 1'b1, 1'b1);
        apply_setting(8'd9, 8'd200, 8'd200, 8'd0, 8'd10);
        push_pix(8'd9, 1'b0, 1'b0); push_pix(8'd200, 1'b0, 1'b0);
        push_pix(8'd50, 1'b0, 1'b0); push_pix(8'd200, 1'b0, 1'b0);
        push_pix(8'd9, 1'b1, 1'b1);

        // Random frames over a sweep of settings; the hold-off phase always runs.
        base  = n_pushed;
        phase = 0;
        while (n_pushed - base < RANDOM_PIXELS || phase < 2) begin
            case (phase)
                0: apply_setting(8'd255, 8'd0, 8'd128, 8'd0, 8'd0);
                1: apply_setting(8'd0, 8'd255, 8'd1, 8'd15, 8'd15);
                2: apply_setting(8'd128, 8'd127, 8'd129, 8'd10, 8'd10);
                default: begin
                    b = rand_level();
                    w = rand_level();
                    r = rand_level();
                    if ($urandom_range(0, 4) == 0) w = b;
                    if ($urandom_range(0, 4) == 0) r = w;
                    apply_setting(b, w, r, rand_tenths(), rand_tenths());
                end
            endcase
            frames = $urandom_range(2, 4);
            for (f = 0; f < frames; f++) begin
                if (phase == 1 && f == 0) begin
                    // receiver holds off while the sender streams: core must back up
                    hold_cycles = LONG_HOLD;
                    push_frame(12, 1'b0);
                end else begin
                    push_frame($urandom_range(1, 8), $urandom_range(0, 3) != 0);
                end
            end
            phase++;
        end

        // One long frame: total and malformed tallies saturate.
        apply_setting(8'd0, 8'd128, 8'd255, 8'd10, 8'd0);
        send_busy = 1'b0;
        push_line(LINE_LANE, 1'b0);
        push_line(LINE_NOISE, 1'b0);
        for (i = 0; i < LONG_FRAME; i++)
            push_pix(8'($urandom_range(0, 255)), 1'b1, i == LONG_FRAME - 1);

        wait_idle();
        if (board.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
